>>> rtl/mep_pkg.sv
// shared constants, types and helper functions of the mandelbrot escape pixel unit
package mep_pkg;

	localparam int PIX_W      = 10;
	localparam int SIDE_W     = 11;
	localparam int LIM_W      = 8;
	localparam int IDX_W      = 20;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 11;
	localparam int MAX_SIDE   = 1024;
	localparam int FRAC_BITS  = 28;
	localparam int WORD_W     = FRAC_BITS + 4;
	localparam int PROD_W     = 2 * WORD_W - FRAC_BITS;
	localparam int SUM_W      = PROD_W + 2;
	localparam int NUM_W      = PIX_W + FRAC_BITS + 2;
	localparam int DIV_CNT_W  = $clog2(NUM_W);

	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT  = CFG_IDX_W'(2);

	localparam logic [SIDE_W-1:0] WIDTH_RST  = SIDE_W'(200);
	localparam logic [SIDE_W-1:0] HEIGHT_RST = SIDE_W'(200);
	localparam logic [LIM_W-1:0]  LIMIT_RST  = LIM_W'(100);

	localparam logic signed [SUM_W-1:0] SAT_HI = (SUM_W'(1) << (WORD_W - 1)) - SUM_W'(1);
	localparam logic signed [SUM_W-1:0] SAT_LO = -(SUM_W'(1) << (WORD_W - 1));
	localparam logic signed [PROD_W:0]  FOUR   = (PROD_W + 1)'(4) << FRAC_BITS;

	typedef logic signed [WORD_W-1:0] word_t;
	typedef logic signed [PROD_W-1:0] fx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIV_RE,
		ST_DIV_IM,
		ST_UPDATE,
		ST_MUL_RR,
		ST_MUL_II,
		ST_MUL_RI,
		ST_CHECK,
		ST_DONE
	} mep_state_t;

	typedef enum logic [1:0] {
		MUL_RR,
		MUL_II,
		MUL_RI
	} mul_sel_t;

	typedef struct packed {
		logic     load;
		logic     div_start_im;
		logic     take_re;
		logic     take_im;
		logic     update;
		mul_sel_t mul_sel;
		logic     store_rr;
		logic     store_ii;
		logic     store_ri;
		logic     emit;
	} mep_cmd_t;

	typedef struct packed {
		logic div_done;
		logic stop;
		logic out_free;
	} mep_sts_t;

	function automatic word_t sat_word(input logic signed [SUM_W-1:0] v);
		word_t r;
		if (v > SAT_HI) begin
			r = SAT_HI[WORD_W-1:0];
		end else if (v < SAT_LO) begin
			r = SAT_LO[WORD_W-1:0];
		end else begin
			r = v[WORD_W-1:0];
		end
		return r;
	endfunction

	function automatic logic [SIDE_W-1:0] eff_side(input logic [SIDE_W-1:0] s);
		logic [SIDE_W-1:0] r;
		if (s == '0) begin
			r = SIDE_W'(1);
		end else if (s > SIDE_W'(MAX_SIDE)) begin
			r = SIDE_W'(MAX_SIDE);
		end else begin
			r = s;
		end
		return r;
	endfunction

endpackage

>>> rtl/mep_if.sv
// pixel, result and configuration channel interfaces
interface mep_pix_if;
	import mep_pkg::*;
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel_row;
	logic [PIX_W-1:0] pixel_column;
	modport source (output valid, output pixel_row, output pixel_column, input ready);
	modport sink (input valid, input pixel_row, input pixel_column, output ready);
endinterface

interface mep_res_if;
	import mep_pkg::*;
	logic             valid;
	logic             ready;
	logic             in_set;
	logic [LIM_W-1:0] iteration_count;
	logic [IDX_W-1:0] result_index;
	modport source (output valid, output in_set, output iteration_count, output result_index,
		input ready);
	modport sink (input valid, input in_set, input iteration_count, input result_index,
		output ready);
endinterface

interface mep_cfg_if;
	import mep_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/mep_div.sv
// iterative restoring divider for the pixel to coordinate mapping
module mep_div (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [mep_pkg::NUM_W-1:0]  num_mag,
	input  logic                    num_neg,
	input  logic [mep_pkg::SIDE_W-1:0] den,
	output logic                    done,
	output mep_pkg::word_t          quot
);
	import mep_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [SIDE_W-1:0]    rem_q;
	logic [NUM_W-1:0]     dq_q;
	logic [SIDE_W-1:0]    den_q;
	logic                 neg_q;
	logic [SIDE_W:0]      rem_sh;
	logic                 ge;
	logic [SIDE_W:0]      rem_sub;
	logic [NUM_W-1:0]     q_hi;

	assign rem_sh  = {rem_q, dq_q[NUM_W-1]};
	assign ge      = rem_sh >= {1'b0, den_q};
	assign rem_sub = rem_sh - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == DIV_CNT_W'(NUM_W - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + DIV_CNT_W'(1);
				if (cnt_q == DIV_CNT_W'(NUM_W - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dq_q  <= num_mag;
			den_q <= den;
			neg_q <= num_neg;
		end else if (busy_q) begin
			rem_q <= ge ? rem_sub[SIDE_W-1:0] : rem_sh[SIDE_W-1:0];
			dq_q  <= {dq_q[NUM_W-2:0], ge};
		end
	end

	// saturate the signed quotient to the word
	assign q_hi = NUM_W'(1) << (WORD_W - 1);
	always_comb begin
		if (neg_q) begin
			quot = (dq_q > q_hi) ? SAT_LO[WORD_W-1:0] : -word_t'(dq_q[WORD_W-1:0]);
		end else begin
			quot = (dq_q >= q_hi) ? SAT_HI[WORD_W-1:0] : word_t'(dq_q[WORD_W-1:0]);
		end
	end

	assign done = done_q;

	property p_done_after_busy;
		@(posedge clk) disable iff (!arst_n) done_q |-> $past(busy_q);
	endproperty
	a_done_after_busy: assert property (p_done_after_busy) else $error("divider done without run");

	property p_busy_no_done;
		@(posedge clk) disable iff (!arst_n) busy_q |-> !done_q || $past(start);
	endproperty
	a_busy_no_done: assert property (p_busy_no_done) else $error("divider done while busy");

	property p_run_length;
		@(posedge clk) disable iff (!arst_n) $rose(done_q) |-> !busy_q;
	endproperty
	a_run_length: assert property (p_run_length) else $error("divider still busy at done");

endmodule

>>> rtl/mep_dpath.sv
// datapath: coordinate mapping, shared multiplier, z update, escape test and output register
module mep_dpath (
	input  logic                       clk,
	input  logic                       arst_n,
	input  mep_pkg::mep_cmd_t          cmd,
	output mep_pkg::mep_sts_t          sts,
	input  logic [mep_pkg::PIX_W-1:0]  pixel_row,
	input  logic [mep_pkg::PIX_W-1:0]  pixel_column,
	input  logic [mep_pkg::SIDE_W-1:0] width_eff,
	input  logic [mep_pkg::SIDE_W-1:0] height_eff,
	input  logic [mep_pkg::LIM_W-1:0]  limit,
	input  logic                       out_ready,
	output logic                       out_valid,
	output logic                       in_set,
	output logic [mep_pkg::LIM_W-1:0]  iteration_count,
	output logic [mep_pkg::IDX_W-1:0]  result_index
);
	import mep_pkg::*;

	logic [PIX_W-1:0]   col_q;
	logic [SIDE_W-1:0]  w_q;
	logic [LIM_W-1:0]   limit_q;
	logic [IDX_W-1:0]   idx_q;
	word_t              cr_q;
	word_t              ci_q;
	word_t              zr_q;
	word_t              zi_q;
	fx_t                rr_q;
	fx_t                ii_q;
	fx_t                ri_q;
	logic [LIM_W-1:0]   k_q;
	logic signed [2*WORD_W-1:0] prod_q;
	logic               out_valid_q;
	logic               in_set_q;
	logic [LIM_W-1:0]   count_q;
	logic [IDX_W-1:0]   res_idx_q;

	logic [PIX_W-1:0]   div_pos;
	logic [SIDE_W-1:0]  div_side;
	logic signed [PIX_W+1:0] diff;
	logic [PIX_W+1:0]   diff_mag;
	logic [NUM_W-1:0]   num_mag;
	logic               div_done;
	word_t              quot;
	word_t              op_a;
	word_t              op_b;
	logic signed [2*WORD_W-1:0] prod_adj;
	fx_t                prod_fx;
	logic signed [SUM_W-1:0] nr_sum;
	logic signed [SUM_W-1:0] ni_sum;
	logic signed [PROD_W:0]  len;
	logic [PIX_W+SIDE_W:0]   idx_full;

	// coordinate division operands
	always_comb begin
		if (cmd.load) begin
			div_pos  = pixel_row;
			div_side = height_eff;
		end else begin
			div_pos  = col_q;
			div_side = w_q;
		end
	end
	assign diff     = $signed({2'b00, div_pos}) - $signed({2'b00, div_side[SIDE_W-1:1]});
	assign diff_mag = diff[PIX_W+1] ? -diff : diff;
	assign num_mag  = {diff_mag[PIX_W-1:0], (FRAC_BITS + 2)'(0)};

	mep_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.load | cmd.div_start_im),
		.num_mag (num_mag),
		.num_neg (diff[PIX_W+1]),
		.den     (div_side),
		.done    (div_done),
		.quot    (quot)
	);

	assign idx_full = (PIX_W + SIDE_W + 1)'(pixel_column) * (PIX_W + SIDE_W + 1)'(height_eff)
		+ (PIX_W + SIDE_W + 1)'(pixel_row);

	// shared multiplier, product registered
	always_comb begin
		case (cmd.mul_sel)
			MUL_RR: begin
				op_a = zr_q;
				op_b = zr_q;
			end
			MUL_II: begin
				op_a = zi_q;
				op_b = zi_q;
			end
			MUL_RI: begin
				op_a = zr_q;
				op_b = zi_q;
			end
			default: begin
				op_a = zr_q;
				op_b = zi_q;
			end
		endcase
	end

	// truncate toward zero
	assign prod_adj = prod_q + (prod_q[2*WORD_W-1] ?
		(2 * WORD_W)'((64'd1 << FRAC_BITS) - 64'd1) : (2 * WORD_W)'(0));
	assign prod_fx  = prod_adj[2*WORD_W-1:FRAC_BITS];

	assign nr_sum = SUM_W'(rr_q) - SUM_W'(ii_q) + SUM_W'(cr_q);
	assign ni_sum = (SUM_W'(ri_q) <<< 1) + SUM_W'(ci_q);
	assign len    = (PROD_W + 1)'(rr_q) + (PROD_W + 1)'(ii_q);

	always_ff @(posedge clk) begin
		prod_q <= op_a * op_b;
		if (cmd.load) begin
			col_q   <= pixel_column;
			w_q     <= width_eff;
			limit_q <= limit;
			idx_q   <= idx_full[IDX_W-1:0];
		end
		if (cmd.take_re) begin
			cr_q <= quot;
		end
		if (cmd.take_im) begin
			ci_q <= quot;
			rr_q <= '0;
			ii_q <= '0;
			ri_q <= '0;
		end
		if (cmd.update) begin
			zr_q <= sat_word(nr_sum);
			zi_q <= sat_word(ni_sum);
		end
		if (cmd.store_rr) begin
			rr_q <= prod_fx;
		end
		if (cmd.store_ii) begin
			ii_q <= prod_fx;
		end
		if (cmd.store_ri) begin
			ri_q <= prod_fx;
		end
		if (cmd.emit) begin
			in_set_q  <= k_q == limit_q;
			count_q   <= k_q;
			res_idx_q <= idx_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.take_im) begin
				k_q <= '0;
			end else if (cmd.update) begin
				k_q <= k_q + LIM_W'(1);
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.div_done = div_done;
	assign sts.stop     = (len >= FOUR) || (k_q >= limit_q);
	assign sts.out_free = !out_valid_q || out_ready;

	assign out_valid       = out_valid_q;
	assign in_set          = in_set_q;
	assign iteration_count = count_q;
	assign result_index    = res_idx_q;

	property p_emit_free;
		@(posedge clk) disable iff (!arst_n) cmd.emit |-> (!out_valid_q || out_ready);
	endproperty
	a_emit_free: assert property (p_emit_free) else $error("result overwritten");

	property p_emit_valid;
		@(posedge clk) disable iff (!arst_n) cmd.emit |=> out_valid_q;
	endproperty
	a_emit_valid: assert property (p_emit_valid) else $error("emitted item not shown");

	property p_squares_pos;
		@(posedge clk) disable iff (!arst_n) cmd.update |-> !rr_q[PROD_W-1] && !ii_q[PROD_W-1];
	endproperty
	a_squares_pos: assert property (p_squares_pos) else $error("negative square");

	property p_count_bound;
		@(posedge clk) disable iff (!arst_n) cmd.emit |-> (k_q <= limit_q || k_q == LIM_W'(1));
	endproperty
	a_count_bound: assert property (p_count_bound) else $error("count past limit");

endmodule

>>> rtl/mep_ctrl.sv
// controller state machine sequencing division, iteration and result hand-off
module mep_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  mep_pkg::mep_sts_t sts,
	output mep_pkg::mep_cmd_t cmd
);
	import mep_pkg::*;

	mep_state_t state_q;
	mep_state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_nxt = ST_DIV_RE;
			end
			ST_DIV_RE: begin
				if (sts.div_done) state_nxt = ST_DIV_IM;
			end
			ST_DIV_IM: begin
				if (sts.div_done) state_nxt = ST_UPDATE;
			end
			ST_UPDATE: state_nxt = ST_MUL_RR;
			ST_MUL_RR: state_nxt = ST_MUL_II;
			ST_MUL_II: state_nxt = ST_MUL_RI;
			ST_MUL_RI: state_nxt = ST_CHECK;
			ST_CHECK: begin
				state_nxt = sts.stop ? ST_DONE : ST_UPDATE;
			end
			ST_DONE: begin
				if (sts.out_free) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		cmd.mul_sel = MUL_RR;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_DIV_RE: begin
				cmd.take_re      = sts.div_done;
				cmd.div_start_im = sts.div_done;
			end
			ST_DIV_IM: cmd.take_im = sts.div_done;
			ST_UPDATE: cmd.update = 1'b1;
			ST_MUL_RR: cmd.mul_sel = MUL_RR;
			ST_MUL_II: begin
				cmd.mul_sel  = MUL_II;
				cmd.store_rr = 1'b1;
			end
			ST_MUL_RI: begin
				cmd.mul_sel  = MUL_RI;
				cmd.store_ii = 1'b1;
			end
			ST_CHECK: cmd.store_ri = 1'b1;
			ST_DONE: cmd.emit = sts.out_free;
			default: cmd = '0;
		endcase
	end

	property p_load_idle;
		@(posedge clk) disable iff (!arst_n) cmd.load |=> state_q == ST_DIV_RE;
	endproperty
	a_load_idle: assert property (p_load_idle) else $error("item taken outside idle");

	property p_emit_idle;
		@(posedge clk) disable iff (!arst_n) cmd.emit |=> in_ready;
	endproperty
	a_emit_idle: assert property (p_emit_idle) else $error("no return to idle after item");

	property p_check_stop;
		@(posedge clk) disable iff (!arst_n)
			(state_q == ST_CHECK && !sts.stop) |=> cmd.update;
	endproperty
	a_check_stop: assert property (p_check_stop) else $error("iteration not continued");

endmodule

>>> rtl/mandelbrot_escape_pixel_unit.sv
// top level of the mandelbrot escape pixel unit with configuration registers
//
// channel  dir  payload                                      handshake
// pix      in   pixel_row, pixel_column                      valid/ready
// res      out  in_set, iteration_count, result_index        valid/ready
// cfg      in   index, data (0 width, 1 height, 2 limit)     valid/ready, always ready
//
// an item runs two divisions on the shared radix-2 divider, then iterates the single
// 32x32 multiplier loop (update, three products, escape check) until it stops; a new
// item is accepted only once the last one has been handed to the result register
// reset loads width 200, height 200, limit 100 and empties the result register
// the result register lets the next item start while the last result waits
// a result still waiting when the next one is done holds the unit until it is taken
module mandelbrot_escape_pixel_unit (
	input logic     clk,
	input logic     arst_n,
	mep_pix_if.sink pix,
	mep_res_if.source res,
	mep_cfg_if.sink cfg
);
	import mep_pkg::*;

	logic [SIDE_W-1:0] width_q;
	logic [SIDE_W-1:0] height_q;
	logic [LIM_W-1:0]  limit_q;
	mep_cmd_t          cmd;
	mep_sts_t          sts;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
			limit_q  <= LIMIT_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_WIDTH:  width_q  <= cfg.data;
				REG_HEIGHT: height_q <= cfg.data;
				REG_LIMIT:  limit_q  <= cfg.data[LIM_W-1:0];
				default: ;
			endcase
		end
	end

	mep_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (pix.valid),
		.in_ready (pix.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	mep_dpath u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.pixel_row       (pix.pixel_row),
		.pixel_column    (pix.pixel_column),
		.width_eff       (eff_side(width_q)),
		.height_eff      (eff_side(height_q)),
		.limit           (limit_q),
		.out_ready       (res.ready),
		.out_valid       (res.valid),
		.in_set          (res.in_set),
		.iteration_count (res.iteration_count),
		.result_index    (res.result_index)
	);

endmodule

>>> dv/tb_top.sv
// testbench for the mandelbrot escape pixel unit: directed pixels, then random config phases
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import mep_pkg::*;

	localparam int     CLK_PERIOD   = 4;
	localparam int     RESET_CYCLES = 12;
	localparam int     TOTAL_PIXELS = 1950;
	localparam int     SETTLE       = 1400;
	localparam longint CYCLE_LIMIT  = 10_000_000;
	localparam int     N_DIRECTED   = 24;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(3);

	localparam longint WORD_MAX = (longint'(1) << (WORD_W - 1)) - 1;
	localparam longint WORD_MIN = -WORD_MAX - 1;
	localparam longint FOUR_FX  = longint'(4) << FRAC_BITS;

	typedef struct packed {
		logic             in_set;
		logic [LIM_W-1:0] iterations;
		logic [IDX_W-1:0] flat_index;
	} escape_t;

	typedef struct packed {
		int width;
		int height;
		int limit;
		int row;
		int column;
		int typed;
		int in_set;
		int iterations;
		int flat_index;
	} directed_row_t;

	// width, height, limit, row, column, typed, in_set, iterations, flat_index
	directed_row_t directed_rows [N_DIRECTED] = '{
		'{200, 200, 100, 100, 100, 1, 1, 100, 20100},
		'{200, 200, 100, 0, 0, 1, 0, 1, 0},
		'{200, 200, 100, 1023, 1023, 1, 0, 1, 205623},
		'{200, 200, 100, 0, 100, 1, 0, 1, 20000},
		'{200, 200, 100, 50, 120, 0, 0, 0, 0},
		'{200, 200, 100, 150, 60, 0, 0, 0, 0},
		'{200, 200, 100, 60, 100, 0, 0, 0, 0},
		'{200, 200, 0, 100, 100, 1, 0, 1, 20100},
		'{200, 200, 0, 30, 170, 1, 0, 1, 34030},
		'{200, 200, 1, 0, 100, 1, 1, 1, 20000},
		'{200, 200, 1, 100, 100, 1, 1, 1, 20100},
		'{200, 200, 2, 0, 100, 1, 0, 1, 20000},
		'{200, 200, 255, 100, 100, 1, 1, 255, 20100},
		'{200, 200, 255, 75, 140, 0, 0, 0, 0},
		'{0, 0, 5, 0, 0, 1, 1, 5, 0},
		'{0, 0, 5, 1023, 1023, 1, 0, 1, 2046},
		'{1, 1, 5, 0, 1023, 1, 0, 1, 1023},
		'{2047, 2047, 5, 512, 512, 1, 1, 5, 524800},
		'{2047, 2047, 5, 1023, 1023, 1, 0, 1, 1048575},
		'{1024, 1024, 20, 300, 600, 0, 0, 0, 0},
		'{1025, 1024, 20, 700, 0, 0, 0, 0, 0},
		'{201, 199, 30, 101, 99, 0, 0, 0, 0},
		'{3, 2, 8, 1, 1, 0, 0, 0, 0},
		'{640, 480, 64, 200, 400, 0, 0, 0, 0}
	};

	logic clk = 1'b0;
	logic arst_n;

	mep_pix_if pix ();
	mep_res_if res ();
	mep_cfg_if cfg ();

	mandelbrot_escape_pixel_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pix    (pix),
		.res    (res),
		.cfg    (cfg)
	);

	logic [SIDE_W-1:0] img_width  = WIDTH_RST;
	logic [SIDE_W-1:0] img_height = HEIGHT_RST;
	logic [LIM_W-1:0]  esc_limit  = LIMIT_RST;

	escape_t pending_escapes [$];
	int      pixels_sent;
	int      results_seen;
	int      mismatches;
	int      settings_used;
	longint  cycles;
	bit      steady;
	int      rx_hold;
	int      rx_pick;

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic longint clamp_word(input longint v);
		if (v > WORD_MAX) begin
			return WORD_MAX;
		end
		if (v < WORD_MIN) begin
			return WORD_MIN;
		end
		return v;
	endfunction

	// product scaled down by the fraction bits, truncated toward zero
	function automatic longint scaled_product(input longint a, input longint b);
		longint ua;
		longint ub;
		longint p;
		ua = (a < 0) ? -a : a;
		ub = (b < 0) ? -b : b;
		p = (ua * ub) >> FRAC_BITS;
		return ((a < 0) != (b < 0)) ? -p : p;
	endfunction

	function automatic longint side_in_use(input logic [SIDE_W-1:0] s);
		if (s == '0) begin
			return 1;
		end
		if (s > MAX_SIDE) begin
			return MAX_SIDE;
		end
		return longint'(s);
	endfunction

	function automatic longint pixel_coord(input logic [PIX_W-1:0] pos, input longint side);
		longint d;
		d = longint'(pos) - side / 2;
		return clamp_word((d * (longint'(1) << (FRAC_BITS + 2))) / side);
	endfunction

	function automatic escape_t escape_time(input logic [PIX_W-1:0] r,
			input logic [PIX_W-1:0] c);
		escape_t e;
		longint  hs;
		longint  ws;
		longint  cr;
		longint  ci;
		longint  zr;
		longint  zi;
		longint  rr;
		longint  ii;
		longint  ri;
		longint  mag;
		int      steps;
		int      lim;
		hs = side_in_use(img_height);
		ws = side_in_use(img_width);
		cr = pixel_coord(r, hs);
		ci = pixel_coord(c, ws);
		zr = 0;
		zi = 0;
		steps = 0;
		lim = int'(esc_limit);
		do begin
			rr = scaled_product(zr, zr);
			ii = scaled_product(zi, zi);
			ri = scaled_product(zr, zi);
			zr = clamp_word(rr - ii + cr);
			zi = clamp_word(2 * ri + ci);
			mag = scaled_product(zr, zr) + scaled_product(zi, zi);
			steps++;
		end while (mag < FOUR_FX && steps < lim);
		e.in_set = (steps == lim);
		e.iterations = LIM_W'(steps);
		e.flat_index = IDX_W'(longint'(c) * hs + longint'(r));
		return e;
	endfunction

	function automatic int pick_gap();
		int p;
		p = $urandom_range(0, 99);
		if (steady || p < 55) begin
			return 0;
		end
		if (p < 85) begin
			return $urandom_range(1, 3);
		end
		if (p < 96) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(30, 120);
	endfunction

	function automatic logic [SIDE_W-1:0] pick_side();
		int p;
		p = $urandom_range(0, 9);
		case (p)
			0: begin
				return SIDE_W'($urandom_range(0, 3));
			end
			1: begin
				return SIDE_W'(MAX_SIDE);
			end
			2: begin
				return SIDE_W'($urandom_range(MAX_SIDE + 1, 2047));
			end
			3: begin
				return SIDE_W'(200);
			end
			default: begin
				return SIDE_W'($urandom_range(4, MAX_SIDE - 1));
			end
		endcase
	endfunction

	function automatic logic [LIM_W-1:0] pick_limit();
		int p;
		p = $urandom_range(0, 11);
		case (p)
			0: begin
				return LIM_W'(255);
			end
			1: begin
				return LIM_W'(100);
			end
			2: begin
				return LIM_W'(0);
			end
			3: begin
				return LIM_W'(1);
			end
			4: begin
				return LIM_W'($urandom_range(64, 254));
			end
			default: begin
				return LIM_W'($urandom_range(2, 48));
			end
		endcase
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= val;
		@(posedge clk);
		while (!cfg.ready) begin
			@(posedge clk);
		end
	endtask

	task automatic set_config(input logic [SIDE_W-1:0] w, input logic [SIDE_W-1:0] h,
			input logic [CFG_DATA_W-1:0] lim_word);
		write_reg(REG_WIDTH, w);
		write_reg(REG_HEIGHT, h);
		write_reg(REG_LIMIT, lim_word);
		write_reg(REG_SPARE, CFG_DATA_W'($urandom_range(0, 2047)));
		cfg.valid <= 1'b0;
		img_width = w;
		img_height = h;
		esc_limit = lim_word[LIM_W-1:0];
		settings_used++;
	endtask

	task automatic send_pixel(input logic [PIX_W-1:0] r, input logic [PIX_W-1:0] c,
			input escape_t want);
		pix.valid <= 1'b1;
		pix.pixel_row <= r;
		pix.pixel_column <= c;
		@(posedge clk);
		while (!pix.ready) begin
			@(posedge clk);
		end
		pending_escapes.push_back(want);
		pixels_sent++;
	endtask

	task automatic pause_sender(input int gap);
		if (gap > 0) begin
			pix.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_all_results();
		pix.valid <= 1'b0;
		while (pending_escapes.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// result side backpressure
	always @(posedge clk) begin
		if (rx_hold > 0) begin
			rx_hold--;
		end else if (steady) begin
			res.ready <= 1'b1;
		end else begin
			rx_pick = $urandom_range(0, 99);
			if (rx_pick < 60) begin
				res.ready <= 1'b1;
				rx_hold = $urandom_range(0, 6);
			end else begin
				res.ready <= 1'b0;
				rx_hold = (rx_pick < 95) ? $urandom_range(0, 3) : $urandom_range(20, 90);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && res.valid && res.ready) begin
			results_seen++;
			if (pending_escapes.size() == 0) begin
				$error("unexpected item: in_set %0d, iteration_count %0d, result_index %0d",
					res.in_set, res.iteration_count, res.result_index);
				mismatches++;
			end else begin
				if (res.in_set !== pending_escapes[0].in_set) begin
					$error("in_set: expected %0d, actual %0d",
						pending_escapes[0].in_set, res.in_set);
					mismatches++;
				end
				if (res.iteration_count !== pending_escapes[0].iterations) begin
					$error("iteration_count: expected %0d, actual %0d",
						pending_escapes[0].iterations, res.iteration_count);
					mismatches++;
				end
				if (res.result_index !== pending_escapes[0].flat_index) begin
					$error("result_index: expected %0d, actual %0d",
						pending_escapes[0].flat_index, res.result_index);
					mismatches++;
				end
				void'(pending_escapes.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		int                    i;
		int                    n;
		int                    quota;
		logic [SIDE_W-1:0]     w;
		logic [SIDE_W-1:0]     h;
		logic [LIM_W-1:0]      lim;
		logic [PIX_W-1:0]      r;
		logic [PIX_W-1:0]      c;
		longint                ew;
		longint                eh;
		escape_t               want;
		directed_row_t         d;

		arst_n = 1'b0;
		pix.valid <= 1'b0;
		pix.pixel_row <= '0;
		pix.pixel_column <= '0;
		cfg.valid <= 1'b0;
		cfg.index <= '0;
		cfg.data <= '0;
		steady <= 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < N_DIRECTED; i++) begin
			d = directed_rows[i];
			if (SIDE_W'(d.width) != img_width || SIDE_W'(d.height) != img_height
					|| LIM_W'(d.limit) != esc_limit) begin
				wait_all_results();
				set_config(SIDE_W'(d.width), SIDE_W'(d.height), CFG_DATA_W'(d.limit));
			end
			if (d.typed != 0) begin
				want.in_set = d.in_set[0];
				want.iterations = LIM_W'(d.iterations);
				want.flat_index = IDX_W'(d.flat_index);
			end else begin
				want = escape_time(PIX_W'(d.row), PIX_W'(d.column));
			end
			send_pixel(PIX_W'(d.row), PIX_W'(d.column), want);
			pause_sender(pick_gap());
		end

		while (pixels_sent < TOTAL_PIXELS) begin
			wait_all_results();
			w = pick_side();
			h = pick_side();
			lim = pick_limit();
			set_config(w, h, {3'($urandom_range(0, 7)), lim});
			steady <= ($urandom_range(0, 3) == 0);
			ew = side_in_use(w);
			eh = side_in_use(h);
			if (lim == LIM_W'(255)) begin
				quota = 30;
			end else if (lim >= LIM_W'(64)) begin
				quota = 60;
			end else begin
				quota = 160;
			end
			if (quota > TOTAL_PIXELS - pixels_sent) begin
				quota = TOTAL_PIXELS - pixels_sent;
			end
			for (n = 0; n < quota; n++) begin
				// mostly pixels inside the image, some anywhere
				if ($urandom_range(0, 4) != 0) begin
					r = PIX_W'($urandom_range(0, int'(eh) - 1));
					c = PIX_W'($urandom_range(0, int'(ew) - 1));
				end else begin
					r = PIX_W'($urandom_range(0, 1023));
					c = PIX_W'($urandom_range(0, 1023));
				end
				send_pixel(r, c, escape_time(r, c));
				if (n == quota / 2 && $urandom_range(0, 2) == 0) begin
					wait_all_results();
				end else begin
					pause_sender(pick_gap());
				end
			end
		end

		wait_all_results();
		repeat (SETTLE) @(posedge clk);
		$display("tb: %0d pixels sent, %0d results checked, %0d register settings",
			pixels_sent, results_seen, settings_used);
		$display("tb: sides 0 to 2047, limits 0 to 255, pixels inside and outside the image");
		if (mismatches == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

>>> sim.f
rtl/mep_pkg.sv
rtl/mep_if.sv
rtl/mep_div.sv
rtl/mep_dpath.sv
rtl/mep_ctrl.sv
rtl/mandelbrot_escape_pixel_unit.sv
dv/tb_top.sv
